// ===== rtl/ccp_pkg.sv =====
// shared types, constants and helper functions of the character constant packer
`default_nettype none

package ccp_pkg;

  localparam int unsigned MAX_BYTES    = 6;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned VALUE_W      = 48;
  localparam int unsigned COUNT_W      = 3;
  localparam int unsigned IN_TDATA_W   = 8;
  localparam int unsigned OUT_TDATA_W  = 56;
  localparam int unsigned OUT_FIELDS_W = VALUE_W + COUNT_W + 1;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_8      = 8'h38;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_UP_L   = 8'h4C;
  localparam logic [7:0] CH_UP_U   = 8'h55;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_B   = 8'h62;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_N   = 8'h6E;
  localparam logic [7:0] CH_LO_R   = 8'h72;
  localparam logic [7:0] CH_LO_T   = 8'h74;
  localparam logic [7:0] CH_LO_U   = 8'h75;
  localparam logic [7:0] CH_LO_V   = 8'h76;
  localparam logic [7:0] CH_LO_X   = 8'h78;

  localparam logic [7:0] ESC_BEL = 8'h07;
  localparam logic [7:0] ESC_BS  = 8'h08;
  localparam logic [7:0] ESC_FF  = 8'h0C;
  localparam logic [7:0] ESC_LF  = 8'h0A;
  localparam logic [7:0] ESC_CR  = 8'h0D;
  localparam logic [7:0] ESC_HT  = 8'h09;
  localparam logic [7:0] ESC_VT  = 8'h0B;

  localparam logic [7:0] UTF_CONT_MASK = 8'hC0;
  localparam logic [7:0] UTF_CONT_VAL  = 8'h80;
  localparam logic [7:0] UTF_LEAD2_MSK = 8'hE0;
  localparam logic [7:0] UTF_LEAD2_VAL = 8'hC0;
  localparam logic [7:0] UTF_LEAD3_MSK = 8'hF0;
  localparam logic [7:0] UTF_LEAD3_VAL = 8'hE0;
  localparam logic [7:0] UTF_LEAD4_MSK = 8'hF8;
  localparam logic [7:0] UTF_LEAD4_VAL = 8'hF0;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_BAD_LEAD = 2'd2,
    ST_BAD_CONT = 2'd3
  } status_e;

  typedef enum logic [7:0] {
    MODE_IDLE    = 8'b0000_0001,
    MODE_AFTER_U = 8'b0000_0010,
    MODE_QUOTE   = 8'b0000_0100,
    MODE_BODY    = 8'b0000_1000,
    MODE_ESC     = 8'b0001_0000,
    MODE_OCT     = 8'b0010_0000,
    MODE_HEX     = 8'b0100_0000,
    MODE_UTF8    = 8'b1000_0000
  } mode_e;

  typedef struct packed {
    logic [BYTE_W-1:0] char_byte;
    logic              lexeme_start;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] literal_value;
    logic [COUNT_W-1:0] byte_count;
    logic               unsigned_type;
    status_e            status;
  } result_t;

  // {valid, digit value}
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= CH_0 && b <= CH_9) begin
      r = {1'b1, 4'(b - CH_0)};
    end else if (b >= CH_LO_A && b <= CH_LO_F) begin
      r = {1'b1, 4'(b - CH_LO_A + 8'd10)};
    end else if (b >= CH_UP_A && b <= CH_UP_F) begin
      r = {1'b1, 4'(b - CH_UP_A + 8'd10)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/char_constant_packer_unit.sv =====
// top level of the character constant packer
//
// Decodes a C character constant arriving one byte per transaction on the
// slave stream: tdata[7:0] is the raw byte, tuser marks the first byte of a
// lexeme. Prefix and quote are skipped, escapes decoded, UTF-8 checked, and
// bytes packed big-endian. On the closing quote, a NUL or an error one result
// comes out on the master stream: tdata holds the value, byte count and
// unsigned flag, tuser the status (ok, too long, bad lead, bad continuation).
// Throughput is one byte per cycle while the result buffer is not full: each
// byte is held in the input register and decoded by the scanner in a single pass.
// The result of the closing byte passes the input register and then the result
// buffer register before it is valid on the master side.
// When the receiver stalls, results collect in a two-entry buffer; once it is
// full the input register holds its byte and slave tready drops.
// Reset empties the input register and the buffer and puts the scanner into
// idle, where bytes are dropped until one arrives with tuser set.
`default_nettype none

module char_constant_packer_unit #(
  parameter int unsigned MaxBytes = ccp_pkg::MAX_BYTES
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [ccp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // char_byte
  input  wire logic                               s_axis_tuser,  // lexeme_start
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // literal_value, byte_count, unsigned_type, zero pad
  output logic [ccp_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  output logic [1:0]                              m_axis_tuser   // status
);
  import ccp_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    take;
  logic    res_valid;
  result_t res;
  result_t out_res;
  logic    fifo_full;

  assign in_item.char_byte    = s_axis_tdata;
  assign in_item.lexeme_start = s_axis_tuser;

  assign take = item_valid && !fifo_full;

  ccp_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  ccp_scan #(
    .MaxBytes (MaxBytes)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (take),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ccp_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (fifo_full),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_res.unsigned_type,
                         out_res.byte_count, out_res.literal_value};
  assign m_axis_tuser = out_res.status;

endmodule

`default_nettype wire

// ===== rtl/ccp_in_stage.sv =====
// input register stage of the character constant packer
`default_nettype none

module ccp_in_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ccp_pkg::item_t in_item_i,
  input  wire logic          take_i,
  output logic               item_valid_o,
  output ccp_pkg::item_t     item_o
);
  import ccp_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  take_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i |-> valid_q)
    else $error("item taken from an empty input register");

endmodule

`default_nettype wire

// ===== rtl/ccp_scan.sv =====
// lexeme scanner state and per-byte decode and pack logic
`default_nettype none

module ccp_scan #(
  parameter int unsigned MaxBytes = ccp_pkg::MAX_BYTES
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire ccp_pkg::item_t item_i,
  output logic                res_valid_o,
  output ccp_pkg::result_t    res_o
);
  import ccp_pkg::*;

  localparam int unsigned CntW = $clog2(MaxBytes + 2);

  mode_e              mode_q, mode_d;
  logic [VALUE_W-1:0] val_q, val_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [7:0]         esc_q, esc_d;
  logic [1:0]         oct_q, oct_d;
  logic [1:0]         utf_q, utf_d;

  logic       fire;
  status_e    fire_st;
  logic       do_body;
  logic       pack_en;
  logic [7:0] pack_byte;
  logic [7:0] b;
  logic [4:0] hx;
  logic [1:0] rem;
  logic       lead_ok;

  assign b  = item_i.char_byte;
  assign hx = hex_digit(b);

  always_comb begin
    mode_d    = mode_q;
    val_d     = val_q;
    cnt_d     = cnt_q;
    esc_d     = esc_q;
    oct_d     = oct_q;
    utf_d     = utf_q;
    fire      = 1'b0;
    fire_st   = ST_OK;
    do_body   = 1'b0;
    pack_en   = 1'b0;
    pack_byte = '0;
    rem       = '0;
    lead_ok   = 1'b0;

    if (step_i && item_i.lexeme_start) begin
      val_d = '0;
      cnt_d = '0;
      esc_d = '0;
      oct_d = '0;
      utf_d = '0;
      if (b == CH_NUL) begin
        fire = 1'b1;
      end else if (b == CH_UP_L || b == CH_UP_U) begin
        mode_d = MODE_QUOTE;
      end else if (b == CH_LO_U) begin
        mode_d = MODE_AFTER_U;
      end else begin
        mode_d = MODE_BODY;
      end
    end else if (step_i) begin
      case (mode_q)
        MODE_AFTER_U: begin
          if (b == CH_NUL) begin
            fire = 1'b1;
          end else begin
            mode_d = (b == CH_8) ? MODE_QUOTE : MODE_BODY;
          end
        end
        MODE_QUOTE: begin
          if (b == CH_NUL) begin
            fire = 1'b1;
          end else begin
            mode_d = MODE_BODY;
          end
        end
        MODE_BODY: begin
          do_body = 1'b1;
        end
        MODE_ESC: begin
          mode_d = MODE_BODY;
          case (b)
            CH_NUL:  fire = 1'b1;
            CH_LO_A: begin pack_en = 1'b1; pack_byte = ESC_BEL; end
            CH_LO_B: begin pack_en = 1'b1; pack_byte = ESC_BS;  end
            CH_LO_F: begin pack_en = 1'b1; pack_byte = ESC_FF;  end
            CH_LO_N: begin pack_en = 1'b1; pack_byte = ESC_LF;  end
            CH_LO_R: begin pack_en = 1'b1; pack_byte = ESC_CR;  end
            CH_LO_T: begin pack_en = 1'b1; pack_byte = ESC_HT;  end
            CH_LO_V: begin pack_en = 1'b1; pack_byte = ESC_VT;  end
            CH_LO_X: begin
              esc_d  = '0;
              mode_d = MODE_HEX;
            end
            default: begin
              if (b inside {[CH_0:CH_7]}) begin
                esc_d  = {5'd0, b[2:0]};
                oct_d  = 2'd1;
                mode_d = MODE_OCT;
              end else begin
                pack_en   = 1'b1;
                pack_byte = b;
              end
            end
          endcase
        end
        MODE_OCT: begin
          if (b inside {[CH_0:CH_7]} && oct_q < 2'd3) begin
            esc_d = {esc_q[4:0], b[2:0]};
            oct_d = oct_q + 2'd1;
            if (oct_q == 2'd2) begin
              mode_d    = MODE_BODY;
              pack_en   = 1'b1;
              pack_byte = esc_d;
            end
          end else begin
            mode_d    = MODE_BODY;
            pack_en   = 1'b1;
            pack_byte = esc_q;
            do_body   = 1'b1;
          end
        end
        MODE_HEX: begin
          if (hx[4]) begin
            esc_d = {esc_q[3:0], hx[3:0]};
          end else begin
            mode_d    = MODE_BODY;
            pack_en   = 1'b1;
            pack_byte = esc_q;
            do_body   = 1'b1;
          end
        end
        MODE_UTF8: begin
          if ((b & UTF_CONT_MASK) != UTF_CONT_VAL) begin
            fire    = 1'b1;
            fire_st = ST_BAD_CONT;
          end else begin
            pack_en   = 1'b1;
            pack_byte = b;
            utf_d     = utf_q - 2'd1;
            if (utf_q == 2'd1) begin
              mode_d = MODE_BODY;
            end
          end
        end
        default: begin
          mode_d = mode_q;
        end
      endcase
    end

    // escape byte or plain byte from the mode logic
    if (pack_en) begin
      val_d = {val_d[VALUE_W-BYTE_W-1:0], pack_byte};
      cnt_d = cnt_d + CntW'(1);
      if (cnt_d > CntW'(MaxBytes)) begin
        fire    = 1'b1;
        fire_st = ST_TOO_LONG;
        do_body = 1'b0;
      end
    end

    // byte handled as a normal body byte, after a flushed escape where needed
    if (do_body) begin
      if (b == CH_QUOTE || b == CH_NUL) begin
        fire = 1'b1;
      end else if (b == CH_BSLASH) begin
        mode_d = MODE_ESC;
      end else begin
        if (!b[7]) begin
          lead_ok = 1'b1;
        end else if ((b & UTF_LEAD2_MSK) == UTF_LEAD2_VAL) begin
          lead_ok = 1'b1;
          rem     = 2'd1;
        end else if ((b & UTF_LEAD3_MSK) == UTF_LEAD3_VAL) begin
          lead_ok = 1'b1;
          rem     = 2'd2;
        end else if ((b & UTF_LEAD4_MSK) == UTF_LEAD4_VAL) begin
          lead_ok = 1'b1;
          rem     = 2'd3;
        end
        if (!lead_ok) begin
          fire    = 1'b1;
          fire_st = ST_BAD_LEAD;
        end else begin
          val_d = {val_d[VALUE_W-BYTE_W-1:0], b};
          cnt_d = cnt_d + CntW'(1);
          if (cnt_d > CntW'(MaxBytes)) begin
            fire    = 1'b1;
            fire_st = ST_TOO_LONG;
          end else if (b[7]) begin
            utf_d  = rem;
            mode_d = MODE_UTF8;
          end
        end
      end
    end

    if (fire) begin
      mode_d = MODE_IDLE;
    end
  end

  always_comb begin
    res_valid_o = fire;
    res_o       = '0;
    res_o.status = fire_st;
    if (fire_st == ST_OK) begin
      res_o.literal_value = val_d;
      res_o.byte_count    = COUNT_W'(cnt_d);
      res_o.unsigned_type = (cnt_d == CntW'(MaxBytes));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      val_q  <= '0;
      cnt_q  <= '0;
      esc_q  <= '0;
      oct_q  <= '0;
      utf_q  <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      val_q  <= val_d;
      cnt_q  <= cnt_d;
      esc_q  <= esc_d;
      oct_q  <= oct_d;
      utf_q  <= utf_d;
    end
  end

  result_needs_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> step_i)
    else $error("result produced without a byte");

  error_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status != ST_OK) |->
      (res_o.literal_value == '0 && res_o.byte_count == '0 && !res_o.unsigned_type))
    else $error("error result carries nonzero fields");

  idle_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> mode_q == MODE_IDLE)
    else $error("scanner not idle after a result");

endmodule

`default_nettype wire

// ===== rtl/ccp_out_fifo.sv =====
// two-entry result buffer decoupling the scanner from the output stall
`default_nettype none

module ccp_out_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire ccp_pkg::result_t push_data_i,
  output logic                  full_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output ccp_pkg::result_t      out_data_o
);
  import ccp_pkg::*;

  result_t    mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign full_o      = (cnt_q == 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("result pushed into a full buffer");

  count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result buffer count out of range");

endmodule

`default_nettype wire

// ===== sim/tb_char_constant_packer_unit.sv =====
// self-checking testbench of the character constant packer: stream stimulus, result predictor
module tb_char_constant_packer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ccp_pkg::*;

  localparam int unsigned CLK_PERIOD   = 20;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned TOTAL_BYTES  = 1450;
  localparam int unsigned QUIET_BYTES  = 1250;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam string ESC_LETTERS = "abfnrtv";
  localparam string HEX_CHARS   = "0123456789abcdefABCDEF";

  class char_const_scoreboard;
    mode_e                 scan;
    logic [VALUE_W-1:0]    packed_val;
    int unsigned           packed_cnt;
    logic [7:0]            esc_val;
    int unsigned           oct_cnt;
    int unsigned           utf8_left;
    result_t               pending[$];
    int unsigned           mismatches;
    int unsigned           checked;
    int unsigned           error_results;

    function new();
      clear();
      mismatches    = 0;
      checked       = 0;
      error_results = 0;
    endfunction

    function void clear();
      scan       = MODE_IDLE;
      packed_val = '0;
      packed_cnt = 0;
      esc_val    = '0;
      oct_cnt    = 0;
      utf8_left  = 0;
    endfunction

    function void close_literal(status_e st);
      result_t r;
      r = '0;
      if (st == ST_OK) begin
        r.literal_value = packed_val;
        r.byte_count    = packed_cnt[COUNT_W-1:0];
        r.unsigned_type = (packed_cnt == MAX_BYTES);
      end
      r.status = st;
      pending.push_back(r);
      scan = MODE_IDLE;
    endfunction

    // returns 1 when the byte overflowed the literal
    function bit push_byte(logic [7:0] b);
      packed_val = {packed_val[VALUE_W-9:0], b};
      packed_cnt++;
      if (packed_cnt > MAX_BYTES) begin
        close_literal(ST_TOO_LONG);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function int hex_nibble(logic [7:0] b);
      if (b >= CH_0 && b <= CH_9) return int'(b - CH_0);
      if (b >= CH_LO_A && b <= CH_LO_F) return int'(b - CH_LO_A) + 10;
      if (b >= CH_UP_A && b <= CH_UP_F) return int'(b - CH_UP_A) + 10;
      return -1;
    endfunction

    function void body_char(logic [7:0] b);
      int unsigned rem;
      if (b == CH_QUOTE || b == CH_NUL) begin
        close_literal(ST_OK);
      end else if (b == CH_BSLASH) begin
        scan = MODE_ESC;
      end else if (!b[7]) begin
        void'(push_byte(b));
      end else begin
        if ((b & UTF_LEAD2_MSK) == UTF_LEAD2_VAL) begin
          rem = 1;
        end else if ((b & UTF_LEAD3_MSK) == UTF_LEAD3_VAL) begin
          rem = 2;
        end else if ((b & UTF_LEAD4_MSK) == UTF_LEAD4_VAL) begin
          rem = 3;
        end else begin
          close_literal(ST_BAD_LEAD);
          return;
        end
        if (!push_byte(b)) begin
          utf8_left = rem;
          scan      = MODE_UTF8;
        end
      end
    endfunction

    function void escape_char(logic [7:0] b);
      scan = MODE_BODY;
      case (b)
        CH_NUL:  close_literal(ST_OK);
        CH_LO_A: void'(push_byte(ESC_BEL));
        CH_LO_B: void'(push_byte(ESC_BS));
        CH_LO_F: void'(push_byte(ESC_FF));
        CH_LO_N: void'(push_byte(ESC_LF));
        CH_LO_R: void'(push_byte(ESC_CR));
        CH_LO_T: void'(push_byte(ESC_HT));
        CH_LO_V: void'(push_byte(ESC_VT));
        CH_LO_X: begin
          esc_val = '0;
          scan    = MODE_HEX;
        end
        default: begin
          if (b >= CH_0 && b <= CH_7) begin
            esc_val = b - CH_0;
            oct_cnt = 1;
            scan    = MODE_OCT;
          end else begin
            void'(push_byte(b));
          end
        end
      endcase
    endfunction

    function void note_item(logic [7:0] b, logic start);
      int h;
      if (start) begin
        clear();
        if (b == CH_NUL) close_literal(ST_OK);
        else if (b == CH_UP_L || b == CH_UP_U) scan = MODE_QUOTE;
        else if (b == CH_LO_U) scan = MODE_AFTER_U;
        else scan = MODE_BODY;
        return;
      end
      case (scan)
        MODE_AFTER_U: begin
          if (b == CH_NUL) close_literal(ST_OK);
          else scan = (b == CH_8) ? MODE_QUOTE : MODE_BODY;
        end
        MODE_QUOTE: begin
          if (b == CH_NUL) close_literal(ST_OK);
          else scan = MODE_BODY;
        end
        MODE_BODY: body_char(b);
        MODE_ESC:  escape_char(b);
        MODE_OCT: begin
          if (b >= CH_0 && b <= CH_7 && oct_cnt < 3) begin
            esc_val = {esc_val[4:0], b[2:0]};
            oct_cnt++;
            if (oct_cnt >= 3) begin
              scan = MODE_BODY;
              void'(push_byte(esc_val));
            end
          end else begin
            scan = MODE_BODY;
            if (!push_byte(esc_val)) body_char(b);
          end
        end
        MODE_HEX: begin
          h = hex_nibble(b);
          if (h >= 0) begin
            esc_val = {esc_val[3:0], 4'(h)};
          end else begin
            scan = MODE_BODY;
            if (!push_byte(esc_val)) body_char(b);
          end
        end
        MODE_UTF8: begin
          if ((b & UTF_CONT_MASK) != UTF_CONT_VAL) begin
            close_literal(ST_BAD_CONT);
          end else if (!push_byte(b)) begin
            utf8_left--;
            if (utf8_left == 0) scan = MODE_BODY;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data, logic [1:0] st);
      result_t exp;
      logic [VALUE_W-1:0] val;
      logic [COUNT_W-1:0] cnt;
      logic               uns;
      val = data[VALUE_W-1:0];
      cnt = data[VALUE_W +: COUNT_W];
      uns = data[VALUE_W+COUNT_W];
      if (pending.size() == 0) begin
        $error("unexpected result: value %h count %0d status %0d", val, cnt, st);
        mismatches++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (exp.status != ST_OK) error_results++;
      if (val !== exp.literal_value) begin
        $error("literal_value: expected %h, actual %h", exp.literal_value, val);
        mismatches++;
      end
      if (cnt !== exp.byte_count) begin
        $error("byte_count: expected %0d, actual %0d", exp.byte_count, cnt);
        mismatches++;
      end
      if (uns !== exp.unsigned_type) begin
        $error("unsigned_type: expected %0b, actual %0b", exp.unsigned_type, uns);
        mismatches++;
      end
      if (st !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, st);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]             m_axis_tuser;

  char_const_scoreboard   sb = new();
  logic [8:0]             stim_q[$];
  int unsigned            stall_cycles = 0;
  int unsigned            gap_pct      = 0;
  bit                     quiet        = 1'b0;

  char_constant_packer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready) sb.note_item(s_axis_tdata, s_axis_tuser);
    end
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("char_constant_packer_unit verification failed");
    $finish;
  end

  // receiver: ready and stall bursts
  initial begin
    int unsigned span;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (quiet || $urandom_range(0, 2) != 0) begin
        m_axis_tready <= 1'b1;
        span = $urandom_range(1, 40);
      end else begin
        m_axis_tready <= 1'b0;
        span = $urandom_range(1, 17);
      end
      repeat (span - 1) @(negedge clk_i);
    end
  end

  function automatic void add_byte(bit start, logic [7:0] b);
    stim_q.push_back({start, b});
  endfunction

  task automatic send_byte(input logic [8:0] it);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 17);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it[7:0];
    s_axis_tuser  <= it[8];
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_queued();
    while (stim_q.size() != 0) send_byte(stim_q.pop_front());
  endtask

  function automatic void load_directed();
    add_byte(1'b0, CH_UP_A);                      // no start yet, dropped
    add_byte(1'b1, CH_UP_L);
    add_byte(1'b0, CH_QUOTE);
    add_byte(1'b0, CH_BSLASH);
    add_byte(1'b0, CH_LO_X);
    add_byte(1'b0, CH_UP_F);
    add_byte(1'b0, CH_LO_F);
    add_byte(1'b0, CH_LO_F);
    add_byte(1'b0, CH_BSLASH);
    add_byte(1'b0, CH_0);
    add_byte(1'b0, CH_BSLASH);                    // ends octal, then escape
    add_byte(1'b0, 8'h7A);                        // unknown escape
    add_byte(1'b0, CH_BSLASH);
    add_byte(1'b0, CH_NUL);                       // nul after backslash
    add_byte(1'b1, CH_NUL);                       // nul in quote slot
    add_byte(1'b1, CH_QUOTE);
    add_byte(1'b0, 8'hFF);                        // bad lead
    add_byte(1'b1, CH_QUOTE);
    add_byte(1'b0, 8'hC3);
    add_byte(1'b0, CH_QUOTE);                     // quote where continuation due
    add_byte(1'b1, CH_QUOTE);
    add_byte(1'b0, 8'h61);
    add_byte(1'b1, CH_LO_U);                      // restart mid-lexeme
    add_byte(1'b0, CH_NUL);
    add_byte(1'b1, CH_UP_U);
    add_byte(1'b0, CH_QUOTE);
    add_byte(1'b0, 8'hF0);
    add_byte(1'b0, 8'h9F);
    add_byte(1'b0, 8'h98);
    add_byte(1'b0, 8'h80);
    add_byte(1'b0, CH_BSLASH);
    add_byte(1'b0, CH_LO_X);                      // empty hex, five bytes total
    add_byte(1'b0, CH_QUOTE);
  endfunction

  function automatic void add_body_part();
    logic [7:0]  b;
    int unsigned len;
    case ($urandom_range(0, 13))
      0, 1, 2, 3: begin
        b = 8'($urandom_range(32, 126));
        if (b == CH_QUOTE || b == CH_BSLASH) b = CH_UP_A;
        add_byte(1'b0, b);
      end
      4, 5: begin
        add_byte(1'b0, CH_BSLASH);
        add_byte(1'b0, ESC_LETTERS[$urandom_range(0, 6)]);
      end
      6: begin
        add_byte(1'b0, CH_BSLASH);
        add_byte(1'b0, 8'($urandom_range(1, 255)));
      end
      7: begin
        add_byte(1'b0, CH_BSLASH);
        repeat ($urandom_range(1, 4)) add_byte(1'b0, CH_0 + 8'($urandom_range(0, 7)));
      end
      8: begin
        add_byte(1'b0, CH_BSLASH);
        add_byte(1'b0, CH_LO_X);
        repeat ($urandom_range(0, 4)) add_byte(1'b0, HEX_CHARS[$urandom_range(0, 21)]);
      end
      9, 10: begin
        len = $urandom_range(2, 4);
        case (len)
          2: add_byte(1'b0, UTF_LEAD2_VAL | 8'($urandom_range(0, 31)));
          3: add_byte(1'b0, UTF_LEAD3_VAL | 8'($urandom_range(0, 15)));
          default: add_byte(1'b0, UTF_LEAD4_VAL | 8'($urandom_range(0, 7)));
        endcase
        repeat (len - 1) add_byte(1'b0, UTF_CONT_VAL | 8'($urandom_range(0, 63)));
      end
      11: add_byte(1'b0, 8'($urandom));
      12: begin
        add_byte(1'b0, UTF_LEAD2_VAL | 8'($urandom_range(0, 31)));
        b = 8'($urandom);
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        add_byte(1'b0, b);
      end
      default: begin
        if ($urandom_range(0, 1) != 0) add_byte(1'b0, 8'($urandom_range(8'h80, 8'hBF)));
        else add_byte(1'b0, 8'($urandom_range(8'hF8, 8'hFF)));
      end
    endcase
  endfunction

  // returns the number of lexeme bytes queued, stray bytes not counted
  function automatic int unsigned build_lexeme();
    int unsigned base;
    int unsigned parts;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) add_byte(1'b0, 8'($urandom));
    end
    base = stim_q.size();
    case ($urandom_range(0, 9))
      0: begin add_byte(1'b1, CH_UP_L); add_byte(1'b0, CH_QUOTE); end
      1: begin add_byte(1'b1, CH_UP_U); add_byte(1'b0, CH_QUOTE); end
      2: begin add_byte(1'b1, CH_LO_U); add_byte(1'b0, CH_QUOTE); end
      3: begin
        add_byte(1'b1, CH_LO_U);
        add_byte(1'b0, CH_8);
        add_byte(1'b0, CH_QUOTE);
      end
      4: begin add_byte(1'b1, CH_LO_U); add_byte(1'b0, 8'($urandom)); end
      5: add_byte(1'b1, 8'($urandom));
      default: add_byte(1'b1, CH_QUOTE);
    endcase
    parts = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 4);
    repeat (parts) add_body_part();
    case ($urandom_range(0, 19))
      0, 1: add_byte(1'b0, CH_NUL);
      2: begin add_byte(1'b0, CH_BSLASH); add_byte(1'b0, CH_NUL); end
      3, 4: ;  // left open, the next start cuts it off
      5: add_byte(1'b0, 8'($urandom));
      default: add_byte(1'b0, CH_QUOTE);
    endcase
    return stim_q.size() - base;
  endfunction

  initial begin
    int unsigned sent;
    int unsigned lexemes;
    sent    = 0;
    lexemes = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    load_directed();
    send_queued();

    while (sent < TOTAL_BYTES) begin
      if (lexemes % 20 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 35;
        endcase
      end
      quiet = (sent >= QUIET_BYTES);
      sent += build_lexeme();
      lexemes++;
      send_queued();
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d random lexemes over %0d bytes after the directed set",
             lexemes, sent);
    $display("%0d results checked, %0d of them error results, %0d mismatches",
             sb.checked, sb.error_results, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("char_constant_packer_unit verification clean");
    end else begin
      $display("char_constant_packer_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ccp_pkg.sv
rtl/ccp_in_stage.sv
rtl/ccp_scan.sv
rtl/ccp_out_fifo.sv
rtl/char_constant_packer_unit.sv
sim/tb_char_constant_packer_unit.sv
